### rtl/core/vvc_pkg.sv
// vvc_pkg: shared widths, constants, register codes, controller states and the
// command/status structs of the volt-var curve unit
// no dependencies
package vvc_pkg;

  // field widths
  localparam int VOLT_W = 16;
  localparam int PWR_W  = 21;
  localparam int APP_W  = 20;
  localparam int REF_W  = 21;
  localparam int LIM_W  = 20;
  localparam int VAR_W  = 11;
  localparam int RATED_W = 20;

  // stream packing
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 56;
  localparam int IN_PWR_LSB  = VOLT_W;
  localparam int IN_APP_LSB  = VOLT_W + PWR_W;
  localparam int OUT_PAD_W   = OUT_TDATA_W - REF_W - LIM_W - VAR_W;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATED    = 3'd0,
    REG_HV_START = 3'd1,
    REG_HV_END   = 3'd2,
    REG_HV_VAR   = 3'd3,
    REG_LV_START = 3'd4,
    REG_LV_END   = 3'd5,
    REG_LV_VAR   = 3'd6
  } vvc_reg_t;

  // reset values of the configuration registers
  localparam logic [RATED_W-1:0]       RST_RATED    = 20'd300000;
  localparam logic [VOLT_W-1:0]        RST_HV_START = 16'd2530;
  localparam logic [VOLT_W-1:0]        RST_HV_END   = 16'd2640;
  localparam logic signed [VAR_W-1:0]  RST_HV_VAR   = 11'sd440;
  localparam logic [VOLT_W-1:0]        RST_LV_START = 16'd2070;
  localparam logic [VOLT_W-1:0]        RST_LV_END   = 16'd1960;
  localparam logic signed [VAR_W-1:0]  RST_LV_VAR   = -11'sd440;

  // lock hysteresis
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] LOCK_TICKS = 4'd10;
  localparam int LOCK_IN_PM  = 200;
  localparam int LOCK_OUT_PM = 100;

  localparam int PERMILLE     = 1000;
  localparam int POWER_MARGIN = 8000;

  // product of power and per-mille scale, and of apparent power and a per-mille value
  localparam int PK_W   = 30;
  localparam int PROD_W = 30;

  // x / 1000 == (x * RECIP_1000) >> RECIP_SHIFT, exact for x below 2**31
  localparam int RECIP_W     = 29;
  localparam int RECIP_SHIFT = 38;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;
  localparam int RMUL_W = PROD_W + RECIP_W;

  // curve divider
  localparam int DVD_W     = VAR_W + VOLT_W;
  localparam int DVS_W     = VOLT_W;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  // square root
  localparam int ROOT_W   = 10;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int SQ_CNT_W = $clog2(ROOT_W + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_LOCK,
    ST_CURVE,
    ST_BRANCH,
    ST_DIV,
    ST_SAT,
    ST_ARG,
    ST_SQRT_GO,
    ST_SQRT,
    ST_PROD,
    ST_RECIP,
    ST_OUT
  } vvc_state_t;

  typedef struct packed {
    logic load;
    logic scale;
    logic lock_upd;
    logic curve;
    logic div_start;
    logic sat;
    logic arg;
    logic sqrt_start;
    logic prod;
    logic recip;
    logic out_load;
  } vvc_cmd_t;

  typedef struct packed {
    logic div_need;
    logic div_busy;
    logic sqrt_busy;
  } vvc_status_t;

endpackage

### rtl/core/vvc_div.sv
// vvc_div: restoring divider, one quotient bit per cycle
// depends on vvc_pkg
module vvc_div
  import vvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVD_W-1:0]     quo_r, quo_nxt;
  logic [DVS_W-1:0]     dvs_r, dvs_nxt;

  logic [DVS_W:0] rem_sh;
  logic [DVS_W:0] diff;
  logic           fits;

  always_comb begin
    rem_sh = {rem_r, quo_r[DVD_W-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    fits   = rem_sh >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DVD_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_nxt  = {quo_r[DVD_W-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = cnt_r != DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

### rtl/core/vvc_sqrt.sv
// vvc_sqrt: bit-pair integer square root, one root bit per cycle
// depends on vvc_pkg
module vvc_sqrt
  import vvc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              busy,
  output logic [ROOT_W-1:0] root
);

  logic                busy_r, busy_nxt;
  logic [SQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RAD_W-1:0]    rad_r, rad_nxt;
  logic [ROOT_W:0]     rem_r, rem_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;

  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] diff;
  logic              fits;

  always_comb begin
    rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    diff   = rem_sh - trial;
    fits   = rem_sh >= trial;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = SQ_CNT_W'(ROOT_W);
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
      root_nxt = {root_r[ROOT_W-2:0], fits};
      rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = cnt_r != SQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

### rtl/core/vvc_dp.sv
// vvc_dp: datapath of the volt-var unit: settings, lock counters, curve,
// reactive reference and active limit arithmetic, result register
// depends on vvc_pkg, vvc_div and vvc_sqrt
module vvc_dp
  import vvc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  vvc_cmd_t               cmd,
  output vvc_status_t            status,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser
);

  localparam logic signed [VAR_W:0] QSAT_HI = (VAR_W+1)'(PERMILLE);
  localparam logic signed [VAR_W:0] QSAT_LO = (VAR_W+1)'(-PERMILLE);

  // settings
  logic [RATED_W-1:0]      rated_r;
  logic [VOLT_W-1:0]       hv_start_r, hv_end_r, lv_start_r, lv_end_r;
  logic signed [VAR_W-1:0] hv_var_r, lv_var_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rated_r    <= RST_RATED;
      hv_start_r <= RST_HV_START;
      hv_end_r   <= RST_HV_END;
      hv_var_r   <= RST_HV_VAR;
      lv_start_r <= RST_LV_START;
      lv_end_r   <= RST_LV_END;
      lv_var_r   <= RST_LV_VAR;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RATED:    rated_r    <= cfg_data[RATED_W-1:0];
        REG_HV_START: hv_start_r <= cfg_data[VOLT_W-1:0];
        REG_HV_END:   hv_end_r   <= cfg_data[VOLT_W-1:0];
        REG_HV_VAR:   hv_var_r   <= cfg_data[VAR_W-1:0];
        REG_LV_START: lv_start_r <= cfg_data[VOLT_W-1:0];
        REG_LV_END:   lv_end_r   <= cfg_data[VOLT_W-1:0];
        REG_LV_VAR:   lv_var_r   <= cfg_data[VAR_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  logic [VOLT_W-1:0]       volt_r;
  logic signed [PWR_W-1:0] pwr_r;
  logic [APP_W-1:0]        app_r;

  // power against rated thresholds
  logic [PK_W-1:0]    pk_r, rout_r, rin_r;
  logic [RATED_W-1:0] rated_eff;
  logic               out_cond, in_cond;

  // lock state
  logic [CNT_W-1:0] lock_in_r, lock_in_nxt, lock_out_r, lock_out_nxt;
  logic [CNT_W-1:0] in_inc, out_inc;
  logic             lock_r, lock_nxt;

  // curve
  logic signed [VAR_W:0] qpre_r, qpre_nxt;
  logic                  div_need_r, div_need_nxt;
  logic [DVD_W-1:0]      dvd_r, dvd_nxt;
  logic [DVS_W-1:0]      dvs_r, dvs_nxt;
  logic                  neg_r, neg_nxt;
  logic [VAR_W-1:0]      hv_mag, lv_mag;
  logic signed [VAR_W:0] hv_negx, lv_negx;
  logic [DVD_W-1:0]      div_quo;
  logic                  div_busy;

  // command and square root
  logic signed [VAR_W-1:0] q_r;
  logic signed [VAR_W:0]   qdiv, qsel, qsat;
  logic [ROOT_W-1:0]       q_mag;
  logic [RAD_W-1:0]        rad_r;
  logic [ROOT_W-1:0]       root;
  logic                    sqrt_busy;

  // products and scaled results
  logic [PROD_W-1:0] plim_r, pref_r;
  logic [RMUL_W-1:0] lim_full, ref_full;
  logic [LIM_W-1:0]  lim_r, refmag_r;

  // result
  logic signed [PWR_W:0]   pwr_x, lim_m;
  logic                    over;
  logic signed [REF_W-1:0] ref_val;
  logic [REF_W-1:0]        ref_o_r;
  logic [LIM_W-1:0]        lim_o_r;
  logic [VAR_W-1:0]        q_o_r;
  logic                    locked_o_r;

  assign rated_eff = (rated_r == '0) ? RATED_W'(1) : rated_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      volt_r <= in_tdata[VOLT_W-1:0];
      pwr_r  <= in_tdata[IN_PWR_LSB +: PWR_W];
      app_r  <= in_tdata[IN_APP_LSB +: APP_W];
    end
    if (cmd.scale) begin
      // only used when the power is not negative
      pk_r   <= PK_W'(pwr_r[PWR_W-2:0]) * PK_W'(PERMILLE);
      rout_r <= PK_W'(rated_eff) * PK_W'(LOCK_OUT_PM + 1);
      rin_r  <= PK_W'(rated_eff) * PK_W'(LOCK_IN_PM);
    end
  end

  // per-mille at or below the exit threshold, or at or above the entry one
  assign out_cond = pwr_r[PWR_W-1] || (pk_r < rout_r);
  assign in_cond  = !out_cond && (pk_r >= rin_r);
  assign in_inc   = lock_in_r + 1'b1;
  assign out_inc  = lock_out_r + 1'b1;

  always_comb begin
    lock_in_nxt  = lock_in_r;
    lock_out_nxt = lock_out_r;
    lock_nxt     = lock_r;
    if (cmd.lock_upd) begin
      if (out_cond) begin
        lock_in_nxt = '0;
        if (out_inc >= LOCK_TICKS) begin
          lock_out_nxt = '0;
          lock_nxt     = 1'b0;
        end else begin
          lock_out_nxt = out_inc;
        end
      end else if (in_cond) begin
        lock_out_nxt = '0;
        if (in_inc >= LOCK_TICKS) begin
          lock_in_nxt = '0;
          lock_nxt    = 1'b1;
        end else begin
          lock_in_nxt = in_inc;
        end
      end else begin
        lock_in_nxt  = '0;
        lock_out_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_in_r  <= '0;
      lock_out_r <= '0;
      lock_r     <= 1'b0;
    end else begin
      lock_in_r  <= lock_in_nxt;
      lock_out_r <= lock_out_nxt;
      lock_r     <= lock_nxt;
    end
  end

  // curve segment selection, high side first
  assign hv_mag  = hv_var_r[VAR_W-1] ? VAR_W'(-hv_var_r) : VAR_W'(hv_var_r);
  assign lv_mag  = lv_var_r[VAR_W-1] ? VAR_W'(-lv_var_r) : VAR_W'(lv_var_r);
  assign hv_negx = -$signed({hv_var_r[VAR_W-1], hv_var_r});
  assign lv_negx = -$signed({lv_var_r[VAR_W-1], lv_var_r});

  always_comb begin
    qpre_nxt     = '0;
    div_need_nxt = 1'b0;
    dvd_nxt      = '0;
    dvs_nxt      = DVS_W'(1);
    neg_nxt      = 1'b0;
    if (lock_r) begin
      if (volt_r > hv_start_r) begin
        if (volt_r < hv_end_r) begin
          div_need_nxt = 1'b1;
          dvd_nxt      = DVD_W'(hv_mag) * DVD_W'(volt_r - hv_start_r);
          dvs_nxt      = hv_end_r - hv_start_r;
          neg_nxt      = !hv_var_r[VAR_W-1];
        end else begin
          qpre_nxt = hv_negx;
        end
      end else if (volt_r < lv_start_r) begin
        if (volt_r > lv_end_r) begin
          div_need_nxt = 1'b1;
          dvd_nxt      = DVD_W'(lv_mag) * DVD_W'(lv_start_r - volt_r);
          dvs_nxt      = lv_start_r - lv_end_r;
          neg_nxt      = !lv_var_r[VAR_W-1];
        end else begin
          qpre_nxt = lv_negx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.curve) begin
      qpre_r     <= qpre_nxt;
      div_need_r <= div_need_nxt;
      dvd_r      <= dvd_nxt;
      dvs_r      <= dvs_nxt;
      neg_r      <= neg_nxt;
    end
  end

  vvc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd_r),
    .divisor  (dvs_r),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // slope quotient stays below the curve magnitude, so eleven bits hold it
  assign qdiv = neg_r ? -$signed({1'b0, div_quo[VAR_W-1:0]})
                      : $signed({1'b0, div_quo[VAR_W-1:0]});
  assign qsel = div_need_r ? qdiv : qpre_r;

  always_comb begin
    if (qsel > QSAT_HI) begin
      qsat = QSAT_HI;
    end else if (qsel < QSAT_LO) begin
      qsat = QSAT_LO;
    end else begin
      qsat = qsel;
    end
  end

  assign q_mag = q_r[VAR_W-1] ? ROOT_W'(-q_r) : ROOT_W'(q_r);

  always_ff @(posedge clk) begin
    if (cmd.sat) begin
      q_r <= VAR_W'(qsat);
    end
    if (cmd.arg) begin
      rad_r <= RAD_W'(PERMILLE * PERMILLE) - RAD_W'(q_mag) * RAD_W'(q_mag);
    end
  end

  vvc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (rad_r),
    .busy     (sqrt_busy),
    .root     (root)
  );

  assign lim_full = RMUL_W'(plim_r) * RMUL_W'(RECIP_1000);
  assign ref_full = RMUL_W'(pref_r) * RMUL_W'(RECIP_1000);

  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      plim_r <= PROD_W'(app_r) * PROD_W'(root);
      pref_r <= PROD_W'(app_r) * PROD_W'(q_mag);
    end
    if (cmd.recip) begin
      lim_r    <= lim_full[RECIP_SHIFT +: LIM_W];
      refmag_r <= ref_full[RECIP_SHIFT +: LIM_W];
    end
  end

  // reference dropped when the power runs past the limit plus margin
  assign pwr_x   = $signed({pwr_r[PWR_W-1], pwr_r});
  assign lim_m   = $signed({1'b0, PWR_W'(lim_r) + PWR_W'(POWER_MARGIN)});
  assign over    = pwr_x > lim_m;
  assign ref_val = over ? '0
                 : (q_r[VAR_W-1] ? -$signed({1'b0, refmag_r}) : $signed({1'b0, refmag_r}));

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ref_o_r    <= ref_val;
      lim_o_r    <= lim_r;
      q_o_r      <= q_r;
      locked_o_r <= lock_r;
    end
  end

  assign out_tdata = {{OUT_PAD_W{1'b0}}, q_o_r, lim_o_r, ref_o_r};
  assign out_tuser = locked_o_r;

  assign status.div_need  = div_need_r;
  assign status.div_busy  = div_busy;
  assign status.sqrt_busy = sqrt_busy;

  a_lock_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (lock_in_r < LOCK_TICKS) && (lock_out_r < LOCK_TICKS))
    else $error("lock counter reached the tick count");

endmodule

### rtl/core/vvc_ctrl.sv
// vvc_ctrl: sequencer of the volt-var unit, drives datapath commands and the
// stream handshakes
// depends on vvc_pkg
module vvc_ctrl
  import vvc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  vvc_status_t status,
  output vvc_cmd_t    cmd
);

  vvc_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_tvalid) state_nxt = ST_SCALE;
      ST_SCALE:   state_nxt = ST_LOCK;
      ST_LOCK:    state_nxt = ST_CURVE;
      ST_CURVE:   state_nxt = ST_BRANCH;
      ST_BRANCH:  state_nxt = status.div_need ? ST_DIV : ST_SAT;
      ST_DIV:     if (!status.div_busy) state_nxt = ST_SAT;
      ST_SAT:     state_nxt = ST_ARG;
      ST_ARG:     state_nxt = ST_SQRT_GO;
      ST_SQRT_GO: state_nxt = ST_SQRT;
      ST_SQRT:    if (!status.sqrt_busy) state_nxt = ST_PROD;
      ST_PROD:    state_nxt = ST_RECIP;
      ST_RECIP:   state_nxt = ST_OUT;
      ST_OUT:     if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_SCALE:   cmd.scale = 1'b1;
      ST_LOCK:    cmd.lock_upd = 1'b1;
      ST_CURVE:   cmd.curve = 1'b1;
      ST_BRANCH:  cmd.div_start = status.div_need;
      ST_SAT:     cmd.sat = 1'b1;
      ST_ARG:     cmd.arg = 1'b1;
      ST_SQRT_GO: cmd.sqrt_start = 1'b1;
      ST_PROD:    cmd.prod = 1'b1;
      ST_RECIP:   cmd.recip = 1'b1;
      ST_OUT:     cmd.out_load = !out_valid_r || out_tready;
      default:    cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten while still held");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_SCALE))
    else $error("accepted request did not start processing");

  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BRANCH && status.div_need) |=> status.div_busy)
    else $error("curve divider did not start");

  a_sqrt_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQRT_GO) |=> status.sqrt_busy)
    else $error("square root unit did not start");

endmodule

### rtl/core/volt_var_curve_with_power_lock_unit.sv
// volt_var_curve_with_power_lock_unit: top level of the volt-var curve unit
// depends on vvc_pkg, vvc_ctrl and vvc_dp
//
// One request per control tick carries the peak grid voltage, the averaged active
// power and the apparent power limit S. The active power, as per-mille of the rated
// power, sets a lock flag after ten ticks in a row at or above 200 and clears it
// after ten ticks in a row at or below 100. While locked, the piecewise-linear
// volt-var curve gives a reactive per-mille command q (saturated to +-1000); the
// result carries q, the reactive reference S*q/1000, the active limit
// S*isqrt((1000+q)(1000-q))/1000 and the lock flag, with the reference forced to
// zero when the power exceeds that limit by more than 8000. One request is worked
// at a time; when the voltage lies on a sloped part of the curve, the time from
// acceptance to result is set mostly by the 27-step curve divider and the 10-step
// square root, and otherwise the divider is skipped.
// The result sits in an output register, so a new request is taken as soon as the
// sequencer is back in idle, even while the previous result waits to be taken.
// Settings are to be written through the cfg port only while the unit is idle, which
// the unit itself does not enforce; they are always accepted.
module volt_var_curve_with_power_lock_unit
  import vvc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [15:0] grid_volt_peak, [36:16] active_power_avg, [56:37] apparent_limit,
  // [63:57] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [20:0] reactive_ref, [40:21] active_limit, [51:41] var_permille, [55:52] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [0] curve_locked
  output logic                   out_tuser,
  // settings write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  vvc_cmd_t    cmd;
  vvc_status_t status;

  // settings registers never stall
  assign cfg_ready = 1'b1;

  vvc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  vvc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
